>>> rtl/core/imu_window_crash_fall_detector_unit_macros.svh
// Assertion macros for the IMU window crash/fall detector.
// Uses clk_i and rst_ni of the module that includes it; no other dependencies.
`ifndef IMU_WINDOW_CRASH_FALL_DETECTOR_UNIT_MACROS_SVH
`define IMU_WINDOW_CRASH_FALL_DETECTOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset only
`define IMUWCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("imuwcf: assertion failed");
// Checked at every edge, reset included
`define IMUWCF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("imuwcf: assertion failed during reset");
`else
`define IMUWCF_ASSERT(lbl, prop)
`define IMUWCF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/imuwcf_pkg.sv
// Shared constants, payload types and helpers for the IMU window crash/fall detector.
// No dependencies; used by imuwcf_csub and the top level.
`default_nettype none

package imuwcf_pkg;

  // Sample and datapath widths
  localparam int SAMPLE_BITS = 16;
  localparam int AXES        = 4;
  localparam int ACC_AXES    = 3;
  localparam int AX_W        = $clog2(AXES);
  localparam int CNT_W       = 16;                 // sample counter
  localparam int N_W         = CNT_W + 1;          // samples summed, up to 2^CNT_W
  localparam int SUM_W       = SAMPLE_BITS + N_W;  // per-axis window sum
  localparam int MAG_W       = SAMPLE_BITS + 1;    // |corrected average|
  localparam int ROOT_W      = MAG_W + 1;          // square root of three squares
  localparam int SQ_W        = 2 * ROOT_W;         // sum of three squares
  localparam int STEP_W      = $clog2(SUM_W + 1);
  // Compare/subtract width: divider remainder or root remainder, whichever is wider
  localparam int UNIT_W      = (MAG_W + 3 > N_W + 1) ? MAG_W + 3 : N_W + 1;

  // Field and register widths
  localparam int LEVEL_W     = 17;
  localparam int FALL_W      = 16;
  localparam int WIN_W       = 16;
  localparam int CLIM_W      = 17;
  localparam int FLIM_W      = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 17;
  localparam int CMP_W       = (ROOT_W > CLIM_W) ? ROOT_W : CLIM_W;
  localparam int FCMP_W      = (MAG_W > FLIM_W) ? MAG_W : FLIM_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CRASH_LIMIT       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FALL_LIMIT        = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [WIN_W-1:0]  WINDOW_RESET      = WIN_W'(500);
  localparam logic [WIN_W-1:0]  CALIBRATION_RESET = WIN_W'(500);
  localparam logic [CLIM_W-1:0] CRASH_RESET       = CLIM_W'(2048);
  localparam logic [FLIM_W-1:0] FALL_RESET        = FLIM_W'(2048);

  // Corrected averages saturate at this magnitude before squaring
  localparam logic [63:0] SAT_MAG = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] crash_level;
    logic               crash;
    logic [FALL_W-1:0]  fall_level;
    logic               fall;
  } out_item_t;

  // Result of the shared compare/subtract unit
  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } csub_res_t;

  function automatic logic [MAG_W-1:0] sat_mag(input logic [MAG_W-1:0] m);
    logic [63:0] wide;
    wide = 64'(m);
    if (wide > SAT_MAG) begin
      sat_mag = MAG_W'(SAT_MAG);
    end else begin
      sat_mag = m;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/imuwcf_csub.sv
// Shared compare/subtract unit: one restoring step for the divider and the square root.
// Depends on imuwcf_pkg.
`default_nettype none

module imuwcf_csub (
  input  logic [imuwcf_pkg::UNIT_W-1:0] a_i,
  input  logic [imuwcf_pkg::UNIT_W-1:0] b_i,
  output imuwcf_pkg::csub_res_t         res_o
);

  logic [imuwcf_pkg::UNIT_W:0] wide_diff;

  // Borrow out of the subtraction means a < b
  assign wide_diff  = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~wide_diff[imuwcf_pkg::UNIT_W];
  assign res_o.diff = wide_diff[imuwcf_pkg::UNIT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/imu_window_crash_fall_detector_unit.sv
// A sample that does not close a window is added to the axis sums. Closing a window runs
// a restoring division of each of the four axis sums (the calibration window ends there and
// gives no result), then the magnitude steps, ROOT_W root steps and an output step that
// registers the result. Throughput: one sample per cycle inside a window; the shared
// compare/subtract unit sets the window-end time. Reset: registers to defaults, sums,
// offsets, counter cleared.
`default_nettype none
`include "imu_window_crash_fall_detector_unit_macros.svh"

module imu_window_crash_fall_detector_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  imuwcf_pkg::in_item_t                in_data_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output imuwcf_pkg::out_item_t               out_data_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imuwcf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [imuwcf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef logic signed [imuwcf_pkg::SUM_W-1:0]       sum_t;
  typedef logic signed [imuwcf_pkg::SAMPLE_BITS-1:0] smp_t;
  typedef logic [imuwcf_pkg::UNIT_W-1:0]             unit_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DLOAD = 6'b000010,
    S_DIV   = 6'b000100,
    S_MAG   = 6'b001000,
    S_ROOT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  // Control state
  state_e                               state_q, state_d;
  logic [imuwcf_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [imuwcf_pkg::AX_W-1:0]          ax_q, ax_d;
  logic [imuwcf_pkg::STEP_W-1:0]        step_q, step_d;
  logic                                 cal_done_q, cal_done_d;
  logic                                 out_valid_q, out_valid_d;
  sum_t                                 sum_q [imuwcf_pkg::AXES];
  sum_t                                 sum_d [imuwcf_pkg::AXES];
  smp_t                                 off_q [imuwcf_pkg::AXES];
  smp_t                                 off_d [imuwcf_pkg::AXES];
  logic [imuwcf_pkg::WIN_W-1:0]         win_q, win_d;
  logic [imuwcf_pkg::WIN_W-1:0]         calib_q, calib_d;
  logic [imuwcf_pkg::CLIM_W-1:0]        crash_lim_q, crash_lim_d;
  logic [imuwcf_pkg::FLIM_W-1:0]        fall_lim_q, fall_lim_d;

  // Datapath
  logic [imuwcf_pkg::N_W-1:0]           n_q, n_d;
  logic                                 neg_q, neg_d;
  logic [imuwcf_pkg::SUM_W-1:0]         dq_q, dq_d;
  unit_t                                rem_q, rem_d;
  smp_t                                 avg_q [imuwcf_pkg::AXES];
  smp_t                                 avg_d [imuwcf_pkg::AXES];
  logic [imuwcf_pkg::SQ_W-1:0]          acc_q, acc_d;
  logic [imuwcf_pkg::MAG_W-1:0]         fall_mag_q, fall_mag_d;
  logic [imuwcf_pkg::SQ_W-1:0]          xs_q, xs_d;
  logic [imuwcf_pkg::ROOT_W-1:0]        root_q, root_d;
  imuwcf_pkg::out_item_t                out_q, out_d;

  // Combinational helpers
  smp_t                                 smp [imuwcf_pkg::AXES];
  logic [imuwcf_pkg::CNT_W-1:0]         cnt_inc;
  logic [imuwcf_pkg::WIN_W-1:0]         need;
  logic                                 win_end;
  unit_t                                unit_a, unit_b;
  imuwcf_pkg::csub_res_t                unit_res;
  logic [imuwcf_pkg::SUM_W-1:0]         quot;
  logic [imuwcf_pkg::SUM_W-1:0]         quot_s;
  logic signed [imuwcf_pkg::MAG_W-1:0]  cdiff;
  logic [imuwcf_pkg::MAG_W-1:0]         mag;
  logic [2*imuwcf_pkg::MAG_W-1:0]       mag_sq;

  logic accept_in;
  logic accept_cfg;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign accept_cfg  = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sample fields in axis order
  always_comb begin
    smp[0] = in_data_i.accel_x;
    smp[1] = in_data_i.accel_y;
    smp[2] = in_data_i.accel_z;
    smp[3] = in_data_i.gyro_z;
  end

  // Window length in force; a zero count acts as one
  always_comb begin
    cnt_inc = cnt_q + imuwcf_pkg::CNT_W'(1);
    need    = cal_done_q ? win_q : calib_q;
    if (need == '0) begin
      need = imuwcf_pkg::WIN_W'(1);
    end
    win_end = (cnt_inc >= need) || (cnt_inc == '0);
  end

  // Operand select for the shared compare/subtract unit
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      S_DIV: begin
        unit_a = {rem_q[imuwcf_pkg::UNIT_W-2:0], dq_q[imuwcf_pkg::SUM_W-1]};
        unit_b = unit_t'(n_q);
      end
      S_ROOT: begin
        unit_a = {rem_q[imuwcf_pkg::UNIT_W-3:0],
                  xs_q[imuwcf_pkg::SQ_W-1:imuwcf_pkg::SQ_W-2]};
        unit_b = unit_t'({root_q, 2'b01});
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  imuwcf_csub u_csub (
    .a_i   (unit_a),
    .b_i   (unit_b),
    .res_o (unit_res)
  );

  // Quotient with the final bit, signed back; corrected magnitude for the axis in turn
  always_comb begin
    quot   = {dq_q[imuwcf_pkg::SUM_W-2:0], unit_res.ge};
    quot_s = neg_q ? (~quot + imuwcf_pkg::SUM_W'(1)) : quot;
    cdiff  = imuwcf_pkg::MAG_W'(avg_q[ax_q]) - imuwcf_pkg::MAG_W'(off_q[ax_q]);
    if (cdiff[imuwcf_pkg::MAG_W-1]) begin
      mag = imuwcf_pkg::sat_mag(~cdiff + imuwcf_pkg::MAG_W'(1));
    end else begin
      mag = imuwcf_pkg::sat_mag(cdiff);
    end
    mag_sq = mag * mag;
  end

  // Sequencer and next-state logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ax_d        = ax_q;
    step_d      = step_q;
    cal_done_d  = cal_done_q;
    out_valid_d = out_valid_q;
    sum_d       = sum_q;
    off_d       = off_q;
    win_d       = win_q;
    calib_d     = calib_q;
    crash_lim_d = crash_lim_q;
    fall_lim_d  = fall_lim_q;
    n_d         = n_q;
    neg_d       = neg_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    avg_d       = avg_q;
    acc_d       = acc_q;
    fall_mag_d  = fall_mag_q;
    xs_d        = xs_q;
    root_d      = root_q;
    out_d       = out_q;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // configuration write; unknown indexes are dropped
    if (accept_cfg) begin
      case (cfg_index_i)
        imuwcf_pkg::REG_WINDOW_COUNT:
          win_d = cfg_data_i[imuwcf_pkg::WIN_W-1:0];
        imuwcf_pkg::REG_CALIBRATION_COUNT:
          calib_d = cfg_data_i[imuwcf_pkg::WIN_W-1:0];
        imuwcf_pkg::REG_CRASH_LIMIT:
          crash_lim_d = cfg_data_i[imuwcf_pkg::CLIM_W-1:0];
        imuwcf_pkg::REG_FALL_LIMIT:
          fall_lim_d = cfg_data_i[imuwcf_pkg::FLIM_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          for (int i = 0; i < imuwcf_pkg::AXES; i++) begin
            sum_d[i] = sum_q[i] + sum_t'(smp[i]);
          end
          if (win_end) begin
            n_d     = (cnt_inc == '0) ? {1'b1, imuwcf_pkg::CNT_W'(0)} : {1'b0, cnt_inc};
            cnt_d   = '0;
            ax_d    = '0;
            state_d = S_DLOAD;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end

      // take the magnitude of one axis sum and clear it
      S_DLOAD: begin
        neg_d        = sum_q[ax_q][imuwcf_pkg::SUM_W-1];
        dq_d         = neg_d ? imuwcf_pkg::SUM_W'(-sum_q[ax_q])
                             : imuwcf_pkg::SUM_W'(sum_q[ax_q]);
        sum_d[ax_q]  = '0;
        rem_d        = '0;
        step_d       = imuwcf_pkg::STEP_W'(imuwcf_pkg::SUM_W);
        state_d      = S_DIV;
      end

      // one restoring division bit per cycle
      S_DIV: begin
        rem_d  = unit_res.ge ? unit_res.diff : unit_a;
        dq_d   = quot;
        step_d = step_q - imuwcf_pkg::STEP_W'(1);
        if (step_q == imuwcf_pkg::STEP_W'(1)) begin
          if (cal_done_q) begin
            avg_d[ax_q] = quot_s[imuwcf_pkg::SAMPLE_BITS-1:0];
          end else begin
            off_d[ax_q] = quot_s[imuwcf_pkg::SAMPLE_BITS-1:0];
          end
          if (ax_q == imuwcf_pkg::AX_W'(imuwcf_pkg::AXES - 1)) begin
            ax_d  = '0;
            acc_d = '0;
            if (cal_done_q) begin
              state_d = S_MAG;
            end else begin
              cal_done_d = 1'b1;
              state_d    = S_IDLE;
            end
          end else begin
            ax_d    = ax_q + imuwcf_pkg::AX_W'(1);
            state_d = S_DLOAD;
          end
        end
      end

      // accumulate squared accel magnitudes, then latch the gyro magnitude
      S_MAG: begin
        if (ax_q == imuwcf_pkg::AX_W'(imuwcf_pkg::ACC_AXES)) begin
          fall_mag_d = mag;
          xs_d       = acc_q;
          rem_d      = '0;
          root_d     = '0;
          step_d     = imuwcf_pkg::STEP_W'(imuwcf_pkg::ROOT_W);
          state_d    = S_ROOT;
        end else begin
          acc_d = acc_q + imuwcf_pkg::SQ_W'(mag_sq);
          ax_d  = ax_q + imuwcf_pkg::AX_W'(1);
        end
      end

      // one root bit per cycle, two radicand bits shifted in
      S_ROOT: begin
        rem_d  = unit_res.ge ? unit_res.diff : unit_a;
        root_d = {root_q[imuwcf_pkg::ROOT_W-2:0], unit_res.ge};
        xs_d   = {xs_q[imuwcf_pkg::SQ_W-3:0], 2'b00};
        step_d = step_q - imuwcf_pkg::STEP_W'(1);
        if (step_q == imuwcf_pkg::STEP_W'(1)) begin
          state_d = S_OUT;
        end
      end

      // load the result register once it is free
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.crash_level = imuwcf_pkg::LEVEL_W'(root_q);
          out_d.crash       = imuwcf_pkg::CMP_W'(root_q) > imuwcf_pkg::CMP_W'(crash_lim_q);
          out_d.fall_level  = imuwcf_pkg::FALL_W'(fall_mag_q);
          out_d.fall        = imuwcf_pkg::FCMP_W'(fall_mag_q) >
                              imuwcf_pkg::FCMP_W'(fall_lim_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ax_q        <= '0;
      step_q      <= '0;
      cal_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < imuwcf_pkg::AXES; i++) begin
        sum_q[i] <= '0;
        off_q[i] <= '0;
      end
      win_q       <= imuwcf_pkg::WINDOW_RESET;
      calib_q     <= imuwcf_pkg::CALIBRATION_RESET;
      crash_lim_q <= imuwcf_pkg::CRASH_RESET;
      fall_lim_q  <= imuwcf_pkg::FALL_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ax_q        <= ax_d;
      step_q      <= step_d;
      cal_done_q  <= cal_done_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      off_q       <= off_d;
      win_q       <= win_d;
      calib_q     <= calib_d;
      crash_lim_q <= crash_lim_d;
      fall_lim_q  <= fall_lim_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    neg_q      <= neg_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    avg_q      <= avg_d;
    acc_q      <= acc_d;
    fall_mag_q <= fall_mag_d;
    xs_q       <= xs_d;
    root_q     <= root_d;
    out_q      <= out_d;
  end

  // Counter is cleared for the whole window-end sequence
  `IMUWCF_ASSERT(a_cnt_clear, ((state_q == S_DLOAD) || (state_q == S_DIV)) |-> (cnt_q == '0))
  // Divider remainder stays below the divisor
  `IMUWCF_ASSERT(a_div_rem, (state_q == S_DIV) |-> (rem_q < unit_t'(n_q)))
  // Root remainder never exceeds twice the partial root
  `IMUWCF_ASSERT(a_root_rem, (state_q == S_ROOT) |-> (rem_q <= (unit_t'(root_q) << 1)))
  // No result before calibration has finished
  `IMUWCF_ASSERT(a_res_after_cal, $rose(out_valid_q) |-> cal_done_q)
  // Result register is empty while reset is held
  `IMUWCF_ASSERT_ALWAYS(a_rst_out, !rst_ni |-> !out_valid_o)

endmodule

`default_nettype wire
